[rtl/tgc_pkg.sv]
// shared constants, register indexes and types of the touch gesture classifier
`default_nettype none

package tgc_pkg;

	// fixed field widths
	localparam int THRESH_BITS   = 20;
	localparam int MARGIN_BITS   = 16;
	localparam int TIME_BITS     = 32;
	localparam int OUT_BITS      = 6;
	localparam int OUT_DATA_BITS = 8;

	// configuration port
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 32;

	typedef logic [CFG_INDEX_BITS-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_SWIPE_THRESHOLD = 3'd0;
	localparam cfg_idx_t REG_EDGE_MARGIN_X   = 3'd1;
	localparam cfg_idx_t REG_EDGE_MARGIN_Y   = 3'd2;
	localparam cfg_idx_t REG_GESTURE_WINDOW  = 3'd3;
	localparam cfg_idx_t REG_HOLD_DELAY      = 3'd4;

	// register reset values
	localparam logic [THRESH_BITS-1:0] RST_SWIPE_THRESHOLD = 20'd655;
	localparam logic [MARGIN_BITS-1:0] RST_EDGE_MARGIN     = 16'd1966;
	localparam logic [TIME_BITS-1:0]   RST_GESTURE_WINDOW  = 32'd2;
	localparam logic [TIME_BITS-1:0]   RST_HOLD_DELAY      = 32'd1;

	// status of the square root unit
	typedef struct packed {
		logic busy;
		logic done;
	} sqrt_stat_t;

endpackage

`default_nettype wire

[rtl/tgc_isqrt.sv]
// bit-serial integer square root, one result bit per cycle
`default_nettype none

module tgc_isqrt import tgc_pkg::*; #(
	parameter int RES_BITS = 17
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [2*RES_BITS-1:0] operand,
	output sqrt_stat_t                 stat,
	output logic      [RES_BITS-1:0]   root
);

	localparam int CntBits = (RES_BITS > 1) ? $clog2(RES_BITS) : 1;
	localparam logic [CntBits-1:0] LastCnt = CntBits'(RES_BITS - 1);

	logic                  busy_q;
	logic [CntBits-1:0]    cnt_q;
	logic [2*RES_BITS-1:0] opnd_q;
	logic [RES_BITS:0]     rem_q;
	logic [RES_BITS-1:0]   root_q;

	logic [RES_BITS+2:0] rem_sh;
	logic [RES_BITS+2:0] trial;
	logic [RES_BITS+3:0] diff;
	logic                fits;
	logic                last;

	// bring down the next two operand bits and try the next root bit
	assign rem_sh = {rem_q, opnd_q[2*RES_BITS-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign diff   = {1'b0, rem_sh} - {1'b0, trial};
	assign fits   = ~diff[RES_BITS+3];
	assign last   = busy_q && (cnt_q == LastCnt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			opnd_q <= operand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			opnd_q <= opnd_q << 2;
			if (fits) begin
				rem_q  <= diff[RES_BITS:0];
				root_q <= {root_q[RES_BITS-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[RES_BITS:0];
				root_q <= {root_q[RES_BITS-2:0], 1'b0};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = last;
	assign root      = root_q;

	// a new root is only started on an idle unit
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("square root restarted while busy");

	// done ends the run
	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		last |=> !busy_q)
		else $error("square root still busy after done");

	// a run keeps going until its last bit
	a_run_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !last && !start) |=> busy_q)
		else $error("square root run cut short");

endmodule

`default_nettype wire

[rtl/touch_gesture_classifier.sv]
// top level of the touch gesture classifier
//
// channel  direction  handshake              payload
// cfg      in         cfg_valid / cfg_ready  cfg_index (register), cfg_data (value)
// s        in         s_tvalid / s_tready    s_tuser pressed, s_tdata pos_x, pos_y, now_us
// m        out        m_tvalid / m_tready    m_tdata six result flags
//
// each report runs through all of its steps before the next request is taken;
// most of its time is in the bit-serial square root, one root bit per cycle;
// the rest is capture, difference, squares, accumulate and classify
// a finished result waits in the output register while the next request is taken
// if the result register is still full and not being taken at classify time, the block waits there
// reset restores the register defaults and the idle touch state; cfg_ready stays high
`default_nettype none

module touch_gesture_classifier import tgc_pkg::*; #(
	parameter int COORD_BITS = 16,
	parameter int DIST_BITS  = 20,
	localparam int InDataBits = ((2 * COORD_BITS + TIME_BITS + 7) / 8) * 8
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// configuration writes
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire cfg_idx_t                 cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
	// touch reports
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [InDataBits-1:0]    s_tdata,   // pos_x, pos_y, now_us, zero pad
	input  wire logic                     s_tuser,   // pressed
	// classification results
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	output logic [OUT_DATA_BITS-1:0]      m_tdata    // in_swipe, in_hold, in_gesture,
	                                                 // touch_changed, class_changed,
	                                                 // touch_now, zero pad
);

	// derived widths
	localparam int RootBits = COORD_BITS + 1;
	localparam int SqBits   = 2 * COORD_BITS;
	localparam int OpBits   = 2 * RootBits;
	localparam int SumBits  = ((DIST_BITS > RootBits) ? DIST_BITS : RootBits) + 1;
	localparam int CmpBits  = (DIST_BITS > THRESH_BITS) ? DIST_BITS : THRESH_BITS;
	localparam int BandBits = ((COORD_BITS > MARGIN_BITS) ? COORD_BITS : MARGIN_BITS) + 2;

	// step limit is 0.2 of the screen, truncated
	localparam logic [RootBits-1:0] StepLimit = RootBits'((64'd1 << COORD_BITS) / 5);
	localparam logic [SumBits-1:0]  DistMax   = SumBits'((64'd1 << DIST_BITS) - 1);
	localparam logic [BandBits-1:0] CoordOne  = BandBits'(1) << COORD_BITS;
	localparam logic [COORD_BITS-1:0] Centre  = COORD_BITS'(1) << (COORD_BITS - 1);

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIFF  = 3'd1;
	localparam logic [2:0] ST_SQ    = 3'd2;
	localparam logic [2:0] ST_ROOT0 = 3'd3;
	localparam logic [2:0] ST_ROOT  = 3'd4;
	localparam logic [2:0] ST_ACC   = 3'd5;
	localparam logic [2:0] ST_FLAG  = 3'd6;

	logic [2:0] state_q;

	// configuration registers
	logic [THRESH_BITS-1:0] thresh_q;
	logic [MARGIN_BITS-1:0] margin_x_q;
	logic [MARGIN_BITS-1:0] margin_y_q;
	logic [TIME_BITS-1:0]   window_q;
	logic [TIME_BITS-1:0]   hold_dly_q;

	// captured request
	logic                  pressed_q;
	logic [COORD_BITS-1:0] x_q;
	logic [COORD_BITS-1:0] y_q;
	logic [TIME_BITS-1:0]  now_q;

	// step datapath
	logic [COORD_BITS-1:0] dx_q;
	logic [COORD_BITS-1:0] dy_q;
	logic [SqBits-1:0]     sqx_q;
	logic [SqBits-1:0]     sqy_q;

	// touch state
	logic                  last_pressed_q;
	logic [COORD_BITS-1:0] last_x_q;
	logic [COORD_BITS-1:0] last_y_q;
	logic [DIST_BITS-1:0]  dist_q;
	logic [COORD_BITS-1:0] start_x_q;
	logic [COORD_BITS-1:0] start_y_q;
	logic [TIME_BITS-1:0]  press_time_q;
	logic [TIME_BITS-1:0]  gest_time_q;
	logic                  gest_started_q;
	logic [2:0]            last_flags_q;
	logic                  touch_chg_q;

	// result register
	logic                m_tvalid_q;
	logic [OUT_BITS-1:0] out_q;

	// square root unit
	logic                sqrt_start;
	logic [OpBits-1:0]   sqrt_operand;
	sqrt_stat_t          sqrt_stat;
	logic [RootBits-1:0] root;

	// classify terms
	logic                 out_free;
	logic [SumBits-1:0]   dist_sum;
	logic [DIST_BITS-1:0] dist_sat;
	logic [TIME_BITS-1:0] hold_elapsed;
	logic [TIME_BITS-1:0] gest_elapsed;
	logic                 swipe;
	logic                 hold;
	logic                 gest_win;
	logic                 band;
	logic                 gest_start;
	logic                 gesture;
	logic [2:0]           flags;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign out_free  = !m_tvalid_q || m_tready;

	// sum of squares feeds the root unit as it is loaded
	assign sqrt_start   = (state_q == ST_ROOT0);
	assign sqrt_operand = OpBits'(sqx_q) + OpBits'(sqy_q);

	tgc_isqrt #(
		.RES_BITS (RootBits)
	) u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sqrt_start),
		.operand (sqrt_operand),
		.stat    (sqrt_stat),
		.root    (root)
	);

	// saturating accumulate of the step
	assign dist_sum = SumBits'(dist_q) + SumBits'(root);
	assign dist_sat = (dist_sum > DistMax) ? DIST_BITS'(DistMax) : dist_sum[DIST_BITS-1:0];

	// classification, all from state settled in the accumulate cycle
	assign hold_elapsed = now_q - press_time_q;
	assign gest_elapsed = now_q - gest_time_q;
	assign swipe    = CmpBits'(dist_q) > CmpBits'(thresh_q);
	assign hold     = pressed_q && (hold_elapsed > hold_dly_q);
	assign gest_win = gest_started_q && (gest_elapsed < window_q);

	// start point near any screen edge
	assign band = (BandBits'(start_x_q) < BandBits'(margin_x_q))
		|| ((BandBits'(start_x_q) + BandBits'(margin_x_q)) > CoordOne)
		|| (BandBits'(start_y_q) < BandBits'(margin_y_q))
		|| ((BandBits'(start_y_q) + BandBits'(margin_y_q)) > CoordOne);

	assign gest_start = !gest_win && swipe && band;
	assign gesture    = gest_win || gest_start;
	assign flags      = {gesture, hold, swipe};

	// configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q   <= RST_SWIPE_THRESHOLD;
			margin_x_q <= RST_EDGE_MARGIN;
			margin_y_q <= RST_EDGE_MARGIN;
			window_q   <= RST_GESTURE_WINDOW;
			hold_dly_q <= RST_HOLD_DELAY;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SWIPE_THRESHOLD: thresh_q   <= cfg_data[THRESH_BITS-1:0];
				REG_EDGE_MARGIN_X:   margin_x_q <= cfg_data[MARGIN_BITS-1:0];
				REG_EDGE_MARGIN_Y:   margin_y_q <= cfg_data[MARGIN_BITS-1:0];
				REG_GESTURE_WINDOW:  window_q   <= cfg_data[TIME_BITS-1:0];
				REG_HOLD_DELAY:      hold_dly_q <= cfg_data[TIME_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer and touch state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			m_tvalid_q     <= 1'b0;
			last_pressed_q <= 1'b0;
			last_x_q       <= '0;
			last_y_q       <= '0;
			dist_q         <= '0;
			start_x_q      <= Centre;
			start_y_q      <= Centre;
			press_time_q   <= '0;
			gest_time_q    <= '0;
			gest_started_q <= 1'b0;
			last_flags_q   <= '0;
			touch_chg_q    <= 1'b0;
		end else begin
			// a new result may replace the one taken at this edge
			if (state_q == ST_FLAG && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF:  state_q <= ST_SQ;
				ST_SQ:    state_q <= ST_ROOT0;
				ST_ROOT0: state_q <= ST_ROOT;
				ST_ROOT: begin
					if (sqrt_stat.done) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					touch_chg_q <= pressed_q != last_pressed_q;
					if (pressed_q) begin
						if (last_pressed_q) begin
							// only short steps count toward the swipe
							if (root < StepLimit) begin
								dist_q <= dist_sat;
							end
						end else begin
							// new press
							press_time_q <= now_q;
							dist_q       <= '0;
							start_x_q    <= x_q;
							start_y_q    <= y_q;
						end
					end
					last_pressed_q <= pressed_q;
					last_x_q       <= x_q;
					last_y_q       <= y_q;
					state_q        <= ST_FLAG;
				end
				ST_FLAG: begin
					if (out_free) begin
						if (gest_start) begin
							gest_time_q    <= now_q;
							gest_started_q <= 1'b1;
						end
						last_flags_q <= flags;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pressed_q <= s_tuser;
			x_q       <= s_tdata[COORD_BITS-1:0];
			y_q       <= s_tdata[2*COORD_BITS-1:COORD_BITS];
			now_q     <= s_tdata[2*COORD_BITS+TIME_BITS-1:2*COORD_BITS];
		end
		if (state_q == ST_DIFF) begin
			dx_q <= (x_q > last_x_q) ? (x_q - last_x_q) : (last_x_q - x_q);
			dy_q <= (y_q > last_y_q) ? (y_q - last_y_q) : (last_y_q - y_q);
		end
		if (state_q == ST_SQ) begin
			sqx_q <= SqBits'(dx_q) * SqBits'(dx_q);
			sqy_q <= SqBits'(dy_q) * SqBits'(dy_q);
		end
		if (state_q == ST_FLAG && out_free) begin
			out_q <= {pressed_q, flags != last_flags_q, touch_chg_q, gesture, hold, swipe};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_DATA_BITS - OUT_BITS){1'b0}}, out_q};

	// a taken request always starts the step datapath
	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_DIFF))
		else $error("request taken but sequencer did not start");

	// the root unit is idle whenever a request can be taken
	a_idle_root: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !sqrt_stat.busy)
		else $error("root unit busy while idle");

	// a new press clears the distance and stamps the press time
	a_press_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC && pressed_q && !last_pressed_q)
		|=> (dist_q == '0 && press_time_q == $past(now_q)))
		else $error("press start not recorded");

	// a classified report lands in the result register
	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLAG && out_free) |=> (m_tvalid && state_q == ST_IDLE))
		else $error("result not presented");

endmodule

`default_nettype wire
